// ===== src/xcrc_pkg.sv =====
`timescale 1ns / 1ps
package xcrc_pkg;

  // input word kinds
  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // configuration register indexes
  localparam logic CFG_SHORT_TMO = 1'b0;
  localparam logic CFG_LONG_TMO  = 1'b1;

  // line control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_C   = 8'h43;

  // session end codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NUM_TO   = 3'd1;
  localparam logic [2:0] ERR_RECORD   = 3'd2;
  localparam logic [2:0] ERR_SEQ      = 3'd3;
  localparam logic [2:0] ERR_HEAD_TO  = 3'd4;

  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned TMO_W   = 16;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // word queue between classifier and sequencer
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QA_W    = 2;

  typedef struct packed {
    logic       start;
    logic       tick;
    logic       rx;
    logic       hdr;   // SOH or STX
    logic       stx;
    logic       eot;
    logic [7:0] data;
  } word_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== src/xcrc_front.sv =====
`timescale 1ns / 1ps
module xcrc_front (
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  input  logic [7:0]       in_rx_byte,
  input  logic             q_full,
  output logic             q_push,
  output xcrc_pkg::word_t  q_word
);

  assign q_push = in_valid & ~q_full;

  always_comb begin
    q_word       = '0;
    q_word.data  = in_rx_byte;
    unique case (in_kind)
      xcrc_pkg::KIND_RX: begin
        q_word.rx  = 1'b1;
        q_word.hdr = (in_rx_byte == xcrc_pkg::CH_SOH) || (in_rx_byte == xcrc_pkg::CH_STX);
        q_word.stx = (in_rx_byte == xcrc_pkg::CH_STX);
        q_word.eot = (in_rx_byte == xcrc_pkg::CH_EOT);
      end
      xcrc_pkg::KIND_TICK: begin
        q_word.tick = 1'b1;
      end
      xcrc_pkg::KIND_START: begin
        q_word.start = 1'b1;
      end
      default: begin
        // unused kind: passes through as a no-op word
      end
    endcase
  end

endmodule

// ===== src/xcrc_fifo.sv =====
`timescale 1ns / 1ps
module xcrc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xcrc_pkg::word_t  push_word,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output xcrc_pkg::word_t  pop_word
);

  xcrc_pkg::word_t                 ent_r [xcrc_pkg::Q_DEPTH];
  logic [xcrc_pkg::QA_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [xcrc_pkg::QA_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [xcrc_pkg::QA_W:0]         cnt_r, cnt_nxt;
  logic                            do_pop;

  assign full      = (cnt_r == (xcrc_pkg::QA_W+1)'(xcrc_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop & not_empty;
  assign pop_word  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_word;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("word queue written while full");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== src/xcrc_back.sv =====
`timescale 1ns / 1ps
module xcrc_back #(
  parameter int unsigned LARGE_BLOCK_BYTES = 1024,
  parameter int unsigned SMALL_BLOCK_BYTES = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [xcrc_pkg::TMO_W-1:0]        cfg_data,
  input  logic                              q_not_empty,
  input  xcrc_pkg::word_t                   q_word,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_send_valid,
  output logic [7:0]                        out_send_byte,
  output logic                              out_data_valid,
  output logic [7:0]                        out_data_byte,
  output logic                              out_block_good,
  output logic                              out_finished,
  output logic [2:0]                        out_error_code,
  output logic [xcrc_pkg::TOTAL_W-1:0]      out_byte_total
);

  localparam int unsigned MAX_BLK = (LARGE_BLOCK_BYTES > SMALL_BLOCK_BYTES) ?
                                    LARGE_BLOCK_BYTES : SMALL_BLOCK_BYTES;
  localparam int unsigned IDX_W   = $clog2(MAX_BLK);
  localparam int unsigned BSZ_W   = IDX_W + 1;
  localparam logic [BSZ_W-1:0] L_SZ = BSZ_W'(LARGE_BLOCK_BYTES);
  localparam logic [BSZ_W-1:0] S_SZ = BSZ_W'(SMALL_BLOCK_BYTES);
  localparam int unsigned TW = xcrc_pkg::TOTAL_W;
  localparam int unsigned KW = xcrc_pkg::TMO_W;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_START  = 4'd1;
  localparam logic [3:0] PH_NUMBER = 4'd2;
  localparam logic [3:0] PH_COMPL  = 4'd3;
  localparam logic [3:0] PH_DATA   = 4'd4;
  localparam logic [3:0] PH_CRCH   = 4'd5;
  localparam logic [3:0] PH_CRCL   = 4'd6;
  localparam logic [3:0] PH_HEAD   = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;

  logic [KW-1:0]    short_tmo_r, long_tmo_r;
  logic [3:0]       phase_r, phase_nxt;
  logic [7:0]       exp_blk_r, exp_blk_nxt;
  logic             large_r, large_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [KW-1:0]    ticks_r, ticks_nxt;
  logic [TW-1:0]    acc_r, acc_nxt;
  logic             first_r, first_nxt;

  logic             out_valid_r;
  logic             send_v_r, data_v_r, good_r, fin_r;
  logic [7:0]       send_b_r, data_b_r;
  logic [2:0]       err_r;
  logic [TW-1:0]    total_r;

  logic             r_send_v, r_data_v, r_good, r_fin;
  logic [7:0]       r_send_b, r_data_b;
  logic [2:0]       r_err;
  logic [TW-1:0]    r_total;

  logic [BSZ_W-1:0] bsize;
  logic [KW-1:0]    limit;
  logic [KW:0]      tick_inc;
  logic             expired;
  logic [BSZ_W-1:0] idx_inc;
  logic [TW:0]      acc_sum;
  logic [15:0]      crc_upd;
  logic             active;

  assign q_pop    = q_not_empty & (~out_valid_r | ~out_stall);
  assign bsize    = large_r ? L_SZ : S_SZ;
  assign limit    = (phase_r == PH_HEAD) ? long_tmo_r : short_tmo_r;
  assign tick_inc = {1'b0, ticks_r} + 1'b1;
  assign expired  = (tick_inc >= {1'b0, limit});
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign acc_sum  = {1'b0, acc_r} + {{(TW + 1 - BSZ_W){1'b0}}, bsize};
  assign crc_upd  = xcrc_pkg::crc16_byte(crc_r, q_word.data);
  assign active   = (phase_r != PH_IDLE) && (phase_r != PH_DONE);

  always_comb begin
    phase_nxt   = phase_r;
    exp_blk_nxt = exp_blk_r;
    large_nxt   = large_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    ticks_nxt   = ticks_r;
    acc_nxt     = acc_r;
    first_nxt   = first_r;
    r_send_v    = 1'b0;
    r_send_b    = '0;
    r_data_v    = 1'b0;
    r_data_b    = '0;
    r_good      = 1'b0;
    r_fin       = 1'b0;
    r_err       = xcrc_pkg::ERR_NONE;
    r_total     = '0;

    if (q_word.start) begin
      phase_nxt   = PH_START;
      exp_blk_nxt = 8'd1;
      large_nxt   = 1'b0;
      idx_nxt     = '0;
      crc_nxt     = '0;
      ticks_nxt   = '0;
      acc_nxt     = '0;
      first_nxt   = 1'b1;
      r_send_v    = 1'b1;
      r_send_b    = xcrc_pkg::CH_C;
    end else if (active && q_word.tick) begin
      ticks_nxt = expired ? '0 : tick_inc[KW-1:0];
      unique case (phase_r)
        PH_START: begin
          if (expired) begin
            r_send_v = 1'b1;
            r_send_b = xcrc_pkg::CH_C;
          end
        end
        PH_NUMBER: begin
          // the first block's number may wait indefinitely
          if (expired && !first_r) begin
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_NUM_TO;
            r_total   = acc_r;
          end
        end
        PH_HEAD: begin
          if (expired) begin
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_HEAD_TO;
            r_total   = acc_r;
          end
        end
        default: begin
          if (expired) begin
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_RECORD;
            r_total   = acc_r;
          end
        end
      endcase
    end else if (active && q_word.rx) begin
      ticks_nxt = '0;
      unique case (phase_r)
        PH_START, PH_HEAD: begin
          if (q_word.hdr) begin
            large_nxt = q_word.stx;
            phase_nxt = PH_NUMBER;
          end else if (phase_r == PH_HEAD && q_word.eot) begin
            r_send_v  = 1'b1;
            r_send_b  = xcrc_pkg::CH_ACK;
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_NONE;
            r_total   = acc_r;
          end else if (phase_r == PH_START) begin
            r_send_v = 1'b1;
            r_send_b = xcrc_pkg::CH_C;
          end
        end
        PH_NUMBER: begin
          if (q_word.data != exp_blk_r) begin
            r_send_v  = 1'b1;
            r_send_b  = xcrc_pkg::CH_NAK;
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_SEQ;
            r_total   = acc_r;
          end else begin
            phase_nxt = PH_COMPL;
          end
        end
        PH_COMPL: begin
          if (q_word.data != ~exp_blk_r) begin
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_RECORD;
            r_total   = acc_r;
          end else begin
            phase_nxt = PH_DATA;
            idx_nxt   = '0;
            crc_nxt   = '0;
          end
        end
        PH_DATA: begin
          r_data_v = 1'b1;
          r_data_b = q_word.data;
          crc_nxt  = crc_upd;
          if (idx_inc >= bsize) begin
            idx_nxt   = '0;
            phase_nxt = PH_CRCH;
          end else begin
            idx_nxt = idx_inc[IDX_W-1:0];
          end
        end
        PH_CRCH: begin
          if (q_word.data != crc_r[15:8]) begin
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_RECORD;
            r_total   = acc_r;
          end else begin
            phase_nxt = PH_CRCL;
          end
        end
        PH_CRCL: begin
          if (q_word.data != crc_r[7:0]) begin
            phase_nxt = PH_DONE;
            r_fin     = 1'b1;
            r_err     = xcrc_pkg::ERR_RECORD;
            r_total   = acc_r;
          end else begin
            r_send_v    = 1'b1;
            r_send_b    = xcrc_pkg::CH_ACK;
            r_good      = 1'b1;
            acc_nxt     = acc_sum[TW] ? {TW{1'b1}} : acc_sum[TW-1:0];
            exp_blk_nxt = exp_blk_r + 8'd1;
            first_nxt   = 1'b0;
            phase_nxt   = PH_HEAD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_tmo_r <= KW'(1000);
      long_tmo_r  <= KW'(5000);
    end else if (cfg_we) begin
      if (cfg_index == xcrc_pkg::CFG_SHORT_TMO) begin
        short_tmo_r <= cfg_data;
      end else begin
        long_tmo_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      exp_blk_r   <= 8'd1;
      large_r     <= 1'b0;
      idx_r       <= '0;
      crc_r       <= '0;
      ticks_r     <= '0;
      acc_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r   <= phase_nxt;
        exp_blk_r <= exp_blk_nxt;
        large_r   <= large_nxt;
        idx_r     <= idx_nxt;
        crc_r     <= crc_nxt;
        ticks_r   <= ticks_nxt;
        acc_r     <= acc_nxt;
        first_r   <= first_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      send_v_r <= r_send_v;
      send_b_r <= r_send_b;
      data_v_r <= r_data_v;
      data_b_r <= r_data_b;
      good_r   <= r_good;
      fin_r    <= r_fin;
      err_r    <= r_err;
      total_r  <= r_total;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_send_valid = send_v_r;
  assign out_send_byte  = send_b_r;
  assign out_data_valid = data_v_r;
  assign out_data_byte  = data_b_r;
  assign out_block_good = good_r;
  assign out_finished   = fin_r;
  assign out_error_code = err_r;
  assign out_byte_total = total_r;

`ifndef ASSERT_OFF
  a_good_acks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_good) |->
      (out_send_valid && out_send_byte == xcrc_pkg::CH_ACK))
    else $error("good block without ACK");
  a_seq_naks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished && out_error_code == xcrc_pkg::ERR_SEQ) |->
      (out_send_valid && out_send_byte == xcrc_pkg::CH_NAK))
    else $error("sequence mismatch without NAK");
  a_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (!out_finished && !out_send_valid))
    else $error("payload word carries control or end status");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> ({1'b0, idx_r} < bsize))
    else $error("payload index beyond block size");
  a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_word.start) |=> (phase_r == PH_START && out_valid))
    else $error("start word did not open a session");
`endif

endmodule

// ===== src/xmodem_crc_block_receiver.sv =====
`timescale 1ns / 1ps
// XMODEM-CRC receiver for 128-byte (SOH) and 1024-byte (STX) blocks. Each input word is a
// received byte, a timer tick or a start command, and each one yields exactly one result
// word carrying any control byte to transmit ('C', ACK, NAK), any payload byte (tentative
// until its block's CRC passes), a block-good flag and, at session end, the error code and
// saturating byte total. Input words go through a 4-entry queue into a sequencer that
// retires one word per clock while the output is not stalled; each word passes through a
// queue entry and then the registered output, and in_stall rises only when the queue
// fills behind a stalled output. Timeouts come from cfg register 0 (short, reset 1000) and
// register 1 (long, reset 5000); write them only while the block is idle.
module xmodem_crc_block_receiver #(
  parameter int unsigned LARGE_BLOCK_BYTES = 1024,
  parameter int unsigned SMALL_BLOCK_BYTES = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [xcrc_pkg::TMO_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_send_valid,
  output logic [7:0]                    out_send_byte,
  output logic                          out_data_valid,
  output logic [7:0]                    out_data_byte,
  output logic                          out_block_good,
  output logic                          out_finished,
  output logic [2:0]                    out_error_code,
  output logic [xcrc_pkg::TOTAL_W-1:0]  out_byte_total
);

  xcrc_pkg::word_t push_word, pop_word;
  logic            push, full, pop, not_empty;

  assign in_stall = full;

  xcrc_front u_front (
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .q_full     (full),
    .q_push     (push),
    .q_word     (push_word)
  );

  xcrc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_word  (pop_word)
  );

  xcrc_back #(
    .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES),
    .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_not_empty    (not_empty),
    .q_word         (pop_word),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_send_valid (out_send_valid),
    .out_send_byte  (out_send_byte),
    .out_data_valid (out_data_valid),
    .out_data_byte  (out_data_byte),
    .out_block_good (out_block_good),
    .out_finished   (out_finished),
    .out_error_code (out_error_code),
    .out_byte_total (out_byte_total)
  );

endmodule

// ===== sim/xmodem_crc_block_receiver_tb.sv =====
`timescale 1ns / 1ps
module xmodem_crc_block_receiver_tb;

  localparam int unsigned LARGE_BYTES    = 1024;
  localparam int unsigned SMALL_BYTES    = 128;
  localparam logic        REG_SHORT_TMO  = xcrc_pkg::CFG_SHORT_TMO;
  localparam logic        REG_LONG_TMO   = xcrc_pkg::CFG_LONG_TMO;
  localparam logic [1:0]  KIND_NOP       = 2'd3;
  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned RANDOM_WORDS   = 1550;
  localparam int unsigned TICK_FAULT_MAX = 40;

  typedef enum logic [3:0] {
    RX_IDLE, RX_START, RX_NUMBER, RX_COMPL, RX_DATA, RX_CRC_HI, RX_CRC_LO, RX_HEADER, RX_DONE
  } rx_phase_t;

  typedef enum int {
    FAULT_NONE, FAULT_NUMBER, FAULT_COMPL, FAULT_DATA, FAULT_CRC_LO, FAULT_TIMEOUT,
    FAULT_NUM_TIMEOUT, FAULT_RESTART
  } block_fault_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        block_good;
    logic        finished;
    logic [2:0]  error_code;
    logic [23:0] byte_total;
  } rx_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic                           cfg_index;
  logic [xcrc_pkg::TMO_W-1:0]     cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     in_kind;
  logic [7:0]                     in_rx_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_send_valid;
  logic [7:0]                     out_send_byte;
  logic                           out_data_valid;
  logic [7:0]                     out_data_byte;
  logic                           out_block_good;
  logic                           out_finished;
  logic [2:0]                     out_error_code;
  logic [xcrc_pkg::TOTAL_W-1:0]   out_byte_total;

  xmodem_crc_block_receiver #(
    .LARGE_BLOCK_BYTES(LARGE_BYTES),
    .SMALL_BLOCK_BYTES(SMALL_BYTES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_send_valid(out_send_valid),
    .out_send_byte(out_send_byte),
    .out_data_valid(out_data_valid),
    .out_data_byte(out_data_byte),
    .out_block_good(out_block_good),
    .out_finished(out_finished),
    .out_error_code(out_error_code),
    .out_byte_total(out_byte_total)
  );

  // receiver model state
  rx_phase_t   ph;
  logic [7:0]  exp_blk;
  bit          big_blk;
  int unsigned idx;
  logic [15:0] crc;
  int unsigned ticks;
  int unsigned total;
  bit          first;
  logic [15:0] short_tmo;
  logic [15:0] long_tmo;

  rx_result_t  pending_results[$];
  int unsigned mismatches;
  int unsigned words_sent;
  bit          idle_en;
  bit          long_hold_req;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] crc_in, logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {d, 8'h00};
    repeat (8) c = {c[14:0], 1'b0} ^ (c[15] ? xcrc_pkg::CRC_POLY : 16'h0000);
    return c;
  endfunction

  function automatic bit tick_expired(int unsigned limit);
    ticks = (ticks + 1) & 32'h1FFFF;
    if (ticks >= limit) begin
      ticks = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic reset_model();
    ph        = RX_IDLE;
    exp_blk   = 8'd1;
    big_blk   = 1'b0;
    idx       = 0;
    crc       = '0;
    ticks     = 0;
    total     = 0;
    first     = 1'b1;
    short_tmo = 16'd1000;
    long_tmo  = 16'd5000;
  endtask

  function automatic rx_result_t predict_receiver(logic [1:0] kind, logic [7:0] b);
    rx_result_t  r;
    bit          ends;
    logic [2:0]  code;
    int unsigned size;
    r    = '0;
    ends = 1'b0;
    code = xcrc_pkg::ERR_NONE;
    size = big_blk ? LARGE_BYTES : SMALL_BYTES;
    if (kind == xcrc_pkg::KIND_START) begin
      ph      = RX_START;
      exp_blk = 8'd1;
      big_blk = 1'b0;
      idx     = 0;
      crc     = '0;
      ticks   = 0;
      total   = 0;
      first   = 1'b1;
      r.send_valid = 1'b1;
      r.send_byte  = xcrc_pkg::CH_C;
      return r;
    end
    if (kind == KIND_NOP || ph == RX_IDLE || ph == RX_DONE) return r;
    if (kind == xcrc_pkg::KIND_TICK) begin
      case (ph)
        RX_START: begin
          if (tick_expired(short_tmo)) begin
            r.send_valid = 1'b1;
            r.send_byte  = xcrc_pkg::CH_C;
          end
        end
        // first block keeps waiting quietly on a number timeout
        RX_NUMBER: begin
          if (tick_expired(short_tmo) && !first) begin
            ends = 1'b1;
            code = xcrc_pkg::ERR_NUM_TO;
          end
        end
        RX_HEADER: begin
          if (tick_expired(long_tmo)) begin
            ends = 1'b1;
            code = xcrc_pkg::ERR_HEAD_TO;
          end
        end
        default: begin
          if (tick_expired(short_tmo)) begin
            ends = 1'b1;
            code = xcrc_pkg::ERR_RECORD;
          end
        end
      endcase
    end else begin
      ticks = 0;
      case (ph)
        RX_START, RX_HEADER: begin
          if (b == xcrc_pkg::CH_SOH || b == xcrc_pkg::CH_STX) begin
            big_blk = (b == xcrc_pkg::CH_STX);
            ph      = RX_NUMBER;
          end else if (ph == RX_HEADER && b == xcrc_pkg::CH_EOT) begin
            r.send_valid = 1'b1;
            r.send_byte  = xcrc_pkg::CH_ACK;
            ends = 1'b1;
            code = xcrc_pkg::ERR_NONE;
          end else if (ph == RX_START) begin
            r.send_valid = 1'b1;
            r.send_byte  = xcrc_pkg::CH_C;
          end
        end
        RX_NUMBER: begin
          if (b != exp_blk) begin
            r.send_valid = 1'b1;
            r.send_byte  = xcrc_pkg::CH_NAK;
            ends = 1'b1;
            code = xcrc_pkg::ERR_SEQ;
          end else begin
            ph = RX_COMPL;
          end
        end
        RX_COMPL: begin
          if (b != 8'(~exp_blk)) begin
            ends = 1'b1;
            code = xcrc_pkg::ERR_RECORD;
          end else begin
            ph  = RX_DATA;
            idx = 0;
            crc = '0;
          end
        end
        RX_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
          crc = crc16_step(crc, b);
          if (idx + 1 >= size) begin
            idx = 0;
            ph  = RX_CRC_HI;
          end else begin
            idx = (idx + 1) & 32'h3FF;
          end
        end
        RX_CRC_HI: begin
          if (b != crc[15:8]) begin
            ends = 1'b1;
            code = xcrc_pkg::ERR_RECORD;
          end else begin
            ph = RX_CRC_LO;
          end
        end
        RX_CRC_LO: begin
          if (b != crc[7:0]) begin
            ends = 1'b1;
            code = xcrc_pkg::ERR_RECORD;
          end else begin
            r.send_valid = 1'b1;
            r.send_byte  = xcrc_pkg::CH_ACK;
            r.block_good = 1'b1;
            total = total + size;
            if (total > 32'hFFFFFF) total = 32'hFFFFFF;
            exp_blk = exp_blk + 8'd1;
            first   = 1'b0;
            ph      = RX_HEADER;
          end
        end
        default: ;
      endcase
    end
    if (ends) begin
      ph           = RX_DONE;
      r.finished   = 1'b1;
      r.error_code = code;
      r.byte_total = total[23:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_word(logic [1:0] kind, logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_receiver(kind, b));
    words_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (index == REG_SHORT_TMO) short_tmo = value;
    else long_tmo = value;
  endtask

  task automatic set_timeouts(logic [15:0] short_val, logic [15:0] long_val);
    wait_idle();
    write_reg(REG_SHORT_TMO, short_val);
    write_reg(REG_LONG_TMO, long_val);
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == xcrc_pkg::CH_SOH || v == xcrc_pkg::CH_STX || v == xcrc_pkg::CH_EOT)
      v = v | 8'h80;
    return v;
  endfunction

  // a few ticks that stay below the timeout
  task automatic benign_ticks(int unsigned limit);
    if (limit > 1 && $urandom_range(0, 39) == 0)
      repeat ($urandom_range(1, (limit - 1 > 3) ? 3 : limit - 1))
        send_word(xcrc_pkg::KIND_TICK, 8'($urandom));
  endtask

  task automatic send_block(logic [7:0] num, bit big, block_fault_t fault, bit first_in_session,
                            output bit ended);
    int unsigned size;
    int unsigned cut;
    logic [15:0] c;
    logic [7:0]  d;
    ended = 1'b1;
    send_word(xcrc_pkg::KIND_RX, big ? xcrc_pkg::CH_STX : xcrc_pkg::CH_SOH);
    if (fault == FAULT_NUM_TIMEOUT) begin
      repeat (short_tmo) send_word(xcrc_pkg::KIND_TICK, 8'($urandom));
      if (!first_in_session) return;
    end
    send_word(xcrc_pkg::KIND_RX,
              (fault == FAULT_NUMBER) ? num + 8'($urandom_range(1, 255)) : num);
    if (fault == FAULT_NUMBER) return;
    send_word(xcrc_pkg::KIND_RX,
              (fault == FAULT_COMPL) ? ~num ^ 8'($urandom_range(1, 255)) : ~num);
    if (fault == FAULT_COMPL) return;
    size = big ? LARGE_BYTES : SMALL_BYTES;
    cut  = (fault == FAULT_TIMEOUT || fault == FAULT_RESTART) ? $urandom_range(0, 20) : size;
    c    = '0;
    for (int unsigned k = 0; k < cut; k++) begin
      d = 8'($urandom);
      benign_ticks(short_tmo);
      send_word(xcrc_pkg::KIND_RX, d);
      c = crc16_step(c, d);
    end
    if (fault == FAULT_TIMEOUT) begin
      repeat (short_tmo) send_word(xcrc_pkg::KIND_TICK, 8'($urandom));
      return;
    end
    if (fault == FAULT_RESTART) begin
      send_word(xcrc_pkg::KIND_START, 8'($urandom));
      return;
    end
    if (fault == FAULT_DATA) c = c ^ 16'($urandom_range(1, 65535));
    send_word(xcrc_pkg::KIND_RX, c[15:8]);
    send_word(xcrc_pkg::KIND_RX,
              (fault == FAULT_CRC_LO) ? c[7:0] ^ 8'($urandom_range(1, 255)) : c[7:0]);
    ended = (fault != FAULT_NONE);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_word(xcrc_pkg::KIND_RX, stray_byte());
      1:       send_word(xcrc_pkg::KIND_TICK, 8'($urandom));
      default: send_word(KIND_NOP, 8'($urandom));
    endcase
  endtask

  task automatic run_session(int unsigned nblocks, bit faults);
    logic [7:0]   num;
    bit           ended;
    bit           big;
    block_fault_t fault;
    send_word(xcrc_pkg::KIND_START, 8'($urandom));
    repeat ($urandom_range(0, 3)) send_noise();
    num = 8'd1;
    for (int unsigned i = 0; i < nblocks; i++) begin
      fault = FAULT_NONE;
      if (faults && $urandom_range(0, 1) == 0) fault = block_fault_t'($urandom_range(1, 7));
      if ((fault == FAULT_TIMEOUT || fault == FAULT_NUM_TIMEOUT) && short_tmo > TICK_FAULT_MAX)
        fault = FAULT_DATA;
      // large blocks only where the block is cut short
      big = fault != FAULT_NONE && fault != FAULT_DATA && fault != FAULT_CRC_LO &&
            $urandom_range(0, 1) == 1;
      send_block(num, big, fault, i == 0, ended);
      if (ended) begin
        repeat ($urandom_range(0, 2)) send_noise();
        return;
      end
      num = num + 8'd1;
      if ($urandom_range(0, 3) == 0) send_word(xcrc_pkg::KIND_RX, stray_byte());
      benign_ticks(long_tmo);
    end
    if (faults && $urandom_range(0, 4) == 0 && long_tmo <= TICK_FAULT_MAX)
      repeat (long_tmo) send_word(xcrc_pkg::KIND_TICK, 8'($urandom));
    else
      send_word(xcrc_pkg::KIND_RX, xcrc_pkg::CH_EOT);
    repeat ($urandom_range(0, 2)) send_noise();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_words();
    send_word(xcrc_pkg::KIND_RX, 8'hFF);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(KIND_NOP, 8'hAA);
    send_word(xcrc_pkg::KIND_START, 8'h55);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_TICK, 8'hFF);
  endtask

  task automatic test_start_retry();
    set_timeouts(16'd2, 16'd3);
    send_word(xcrc_pkg::KIND_RX, 8'h00);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_RX, xcrc_pkg::CH_SOH);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_RX, 8'h05);
    send_word(xcrc_pkg::KIND_RX, 8'h01);
  endtask

  task automatic test_record_errors();
    send_word(xcrc_pkg::KIND_START, 8'h00);
    send_word(xcrc_pkg::KIND_RX, xcrc_pkg::CH_STX);
    send_word(xcrc_pkg::KIND_RX, 8'h01);
    send_word(xcrc_pkg::KIND_RX, 8'h00);
    send_word(xcrc_pkg::KIND_START, 8'h00);
    send_word(xcrc_pkg::KIND_RX, xcrc_pkg::CH_SOH);
    send_word(xcrc_pkg::KIND_RX, 8'h01);
    send_word(xcrc_pkg::KIND_RX, 8'hFE);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(xcrc_pkg::KIND_START, 8'h00);
    send_word(xcrc_pkg::KIND_RX, xcrc_pkg::CH_SOH);
    send_word(xcrc_pkg::KIND_START, 8'h00);
  endtask

  task automatic test_zero_timeout();
    set_timeouts(16'd0, 16'd3);
    send_word(xcrc_pkg::KIND_TICK, 8'h00);
    send_word(KIND_NOP, 8'h00);
  endtask

  task automatic test_large_block();
    bit ended;
    set_timeouts(16'hFFFF, 16'hFFFF);
    send_word(xcrc_pkg::KIND_START, 8'h00);
    send_block(8'd1, 1'b1, FAULT_NONE, 1'b1, ended);
    send_block(8'd2, 1'b0, FAULT_NONE, 1'b0, ended);
    send_word(xcrc_pkg::KIND_RX, xcrc_pkg::CH_EOT);
  endtask

  task automatic test_random_sessions(int unsigned start_count);
    int unsigned p;
    p = 0;
    while (p < 5 || words_sent - start_count < RANDOM_WORDS) begin
      case (p % 5)
        0: set_timeouts(16'd1, 16'd1);
        1: set_timeouts(16'd3, 16'd7);
        2: set_timeouts(16'($urandom_range(2, 12)), 16'($urandom_range(2, 30)));
        3: set_timeouts(16'hFFFF, 16'd2);
        default: set_timeouts(16'd5, 16'hFFFF);
      endcase
      repeat (2) run_session($urandom_range(0, 1), 1'b1);
      p++;
    end
  endtask

  task automatic test_backpressure();
    set_timeouts(16'd20, 16'd40);
    long_hold_req = 1'b1;
    run_session(1, 1'b0);
  endtask

  task automatic test_no_idle();
    wait_idle();
    idle_en = 1'b0;
    set_timeouts(16'd6, 16'd9);
    run_session(2, 1'b1);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [23:0] got, logic [23:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", 24'd1, 24'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("send_valid", out_send_valid, want.send_valid);
        check_field("send_byte", out_send_byte, want.send_byte);
        check_field("data_valid", out_data_valid, want.data_valid);
        check_field("data_byte", out_data_byte, want.data_byte);
        check_field("block_good", out_block_good, want.block_good);
        check_field("finished", out_finished, want.finished);
        check_field("error_code", out_error_code, want.error_code);
        check_field("byte_total", out_byte_total, want.byte_total);
      end
    end
  end

  // output stall: random short bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("xmodem_crc_block_receiver: mismatch");
    $finish;
  end

  initial begin : main
    int unsigned random_start;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SHORT_TMO;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_kind       = xcrc_pkg::KIND_RX;
    in_rx_byte    = 8'h00;
    mismatches    = 0;
    words_sent    = 0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_words();
    test_start_retry();
    test_record_errors();
    test_zero_timeout();
    random_start = words_sent;
    test_large_block();
    test_random_sessions(random_start);
    test_backpressure();
    test_no_idle();

    wait_idle();
    if (mismatches == 0) begin
      $display("xmodem_crc_block_receiver: match");
    end else begin
      $display("xmodem_crc_block_receiver: mismatch");
    end
    $finish;
  end

endmodule
